// File: rtl/miller_rabin_witness_test_defines.svh
// Assertion macros for the Miller-Rabin witness test checker.
`ifndef MILLER_RABIN_WITNESS_TEST_DEFINES_SVH
`define MILLER_RABIN_WITNESS_TEST_DEFINES_SVH

// a implies b on the next clock edge, outside reset
`define MRW_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

// a implies b on the same clock edge, outside reset
`define MRW_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

`endif

// File: rtl/mrw_pkg.sv
// Shared types for the Miller-Rabin witness test.
`timescale 1ns / 1ps
package mrw_pkg;
   typedef struct packed {
      logic load;
      logic mul_start;
      logic mul_sel_sq;
      logic mul_dst_x;
      logic shift_e;
      logic set_x;
   } cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic bad;
      logic even;
      logic d_even;
      logic e_zero;
      logic e_lsb;
      logic x_one;
      logic x_nm1;
      logic s_more;
   } sts_type;
endpackage

// File: rtl/miller_rabin_witness_test.sv
// Top level of the Miller-Rabin witness test.
//  channel  direction  fields
//  req      in         tdata: candidate, witness
//  rsp      out        tdata: composite, bad_input
// One item at a time; roughly 2*W modular products worst case, each
// computed by the bit-serial multiplier.
// Synchronous reset clears control; a stalled result holds the controller.
`timescale 1ns / 1ps
module miller_rabin_witness_test #(
   parameter int NUM_WIDTH = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // candidate [30:0], witness [61:31]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // composite [0], bad_input [1]
);
   mrw_pkg::cmd_type cmd;
   mrw_pkg::sts_type sts;
   logic composite, bad_input;

   mrw_datapath #(.W(NUM_WIDTH)) u_dp (
      .clock(clock), .reset(reset),
      .n_in_val(NUM_WIDTH'(req_tdata[30:0])),
      .a_in_val(NUM_WIDTH'(req_tdata[61:31])),
      .cmd(cmd), .sts(sts)
   );

   mrw_control u_ctl (
      .clock(clock), .reset(reset), .req_fire(req_tvalid),
      .req_tready(req_tready), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .composite(composite), .bad_input(bad_input), .cmd(cmd), .sts(sts)
   );

   assign rsp_tdata = {6'b0, bad_input, composite};
endmodule

// File: rtl/mrw_datapath.sv
// Datapath: operand registers and a bit-serial modular multiplier.
`timescale 1ns / 1ps
module mrw_datapath #(
   parameter int W = 31
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [W-1:0]    n_in_val,
   input  logic [W-1:0]    a_in_val,
   input  mrw_pkg::cmd_type cmd,
   output mrw_pkg::sts_type sts
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  n_ff, b_ff, e_ff, x_ff, acc_ff;
   logic [CW-1:0] s_ff;
   logic [W-1:0]  mx_ff, my_ff;
   logic [W:0]    r_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, dst_x_ff;

   logic [W:0] r2, r3, rn;
   logic [W:0] nn;

   assign nn = {1'b0, n_ff};

   always_comb begin
      r2 = {r_ff[W-1:0], 1'b0};
      if (r2 >= nn) r2 = r2 - nn;
      r3 = r2 + {1'b0, mx_ff};
      if (r3 >= nn) r3 = r3 - nn;
      rn = my_ff[W-1] ? r3 : r2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.mul_start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(W);
         r_ff    <= '0;
         dst_x_ff <= cmd.mul_dst_x;
         if (cmd.mul_sel_sq) begin
            // squaring works on the register it writes back to
            mx_ff <= cmd.mul_dst_x ? acc_ff : b_ff;
            my_ff <= cmd.mul_dst_x ? acc_ff : b_ff;
         end else begin
            mx_ff <= acc_ff;
            my_ff <= b_ff;
         end
      end else if (busy_ff) begin
         r_ff  <= rn;
         my_ff <= {my_ff[W-2:0], 1'b0};
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            if (dst_x_ff) acc_ff <= rn[W-1:0];
            else          b_ff   <= rn[W-1:0];
         end
      end
      if (cmd.load) begin
         n_ff   <= n_in_val;
         b_ff   <= a_in_val;
         e_ff   <= n_in_val - 1'b1;
         acc_ff <= W'(1);
         s_ff   <= '0;
      end
      if (cmd.shift_e) begin
         e_ff <= e_ff >> 1;
         if (cmd.mul_dst_x) s_ff <= s_ff + 1'b1;
      end
      // one squaring of the chain used up
      if (cmd.mul_start && cmd.mul_sel_sq && cmd.mul_dst_x && s_ff != '0)
         s_ff <= s_ff - 1'b1;
      if (cmd.set_x && !cmd.shift_e) b_ff <= acc_ff;
   end

   assign x_ff = acc_ff;
   assign sts.mul_busy = busy_ff;
   assign sts.bad    = (n_ff < W'(5)) || (b_ff < W'(2)) || (b_ff > n_ff - W'(2));
   assign sts.even   = ~n_ff[0];
   assign sts.d_even = ~e_ff[0];
   assign sts.e_zero = (e_ff == '0);
   assign sts.e_lsb  = e_ff[0];
   assign sts.x_one  = (x_ff == W'(1));
   assign sts.x_nm1  = (x_ff == n_ff - W'(1));
   assign sts.s_more = (s_ff > CW'(1));
endmodule

// File: rtl/mrw_control.sv
// Controller: sequences factoring, exponentiation and the squaring chain.
`timescale 1ns / 1ps
module mrw_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_fire,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             composite,
   output logic             bad_input,
   output mrw_pkg::cmd_type cmd,
   input  mrw_pkg::sts_type sts
);
   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_FACTOR, S_POW, S_MUL, S_MULW, S_SQ, S_SQW,
      S_TEST, S_CHAIN, S_CHAINW, S_DONE
   } state_type;

   state_type state_ff;
   logic      first_ff;

   assign req_tready = (state_ff == S_IDLE) || (rsp_tvalid && rsp_tready);

   always_comb begin
      cmd = '0;
      cmd.load = req_fire && req_tready;
      case (state_ff)
         S_FACTOR: if (sts.d_even) begin
            cmd.shift_e = 1'b1;
            cmd.mul_dst_x = 1'b1;
         end
         S_POW: if (!sts.e_zero && sts.e_lsb) begin
            cmd.mul_start = 1'b1;
            cmd.mul_dst_x = 1'b1;
         end
         S_SQ: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel_sq = 1'b1;
         end
         S_MUL: cmd.shift_e = 1'b1;
         S_TEST: cmd.set_x = 1'b1;
         S_CHAIN: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel_sq = 1'b1;
            cmd.mul_dst_x = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_tvalid <= 1'b0;
         first_ff   <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) rsp_tvalid <= 1'b0;
         case (state_ff)
            S_IDLE, S_DONE: begin
               if (state_ff == S_DONE && !(rsp_tvalid && rsp_tready) && rsp_tvalid)
                  state_ff <= S_DONE;
               else if (req_fire) state_ff <= S_CHECK;
               else state_ff <= S_IDLE;
            end
            S_CHECK: begin
               if (sts.bad || sts.even) begin
                  composite  <= !sts.bad;
                  bad_input  <= sts.bad;
                  rsp_tvalid <= 1'b1;
                  state_ff   <= S_DONE;
               end else state_ff <= S_FACTOR;
            end
            S_FACTOR: if (!sts.d_even) state_ff <= S_POW;
            S_POW: begin
               if (sts.e_zero) state_ff <= S_TEST;
               else if (sts.e_lsb) state_ff <= S_MULW;
               else state_ff <= S_SQ;
            end
            S_MULW: if (!sts.mul_busy) state_ff <= S_SQ;
            S_SQ: state_ff <= S_SQW;
            S_SQW: if (!sts.mul_busy) state_ff <= S_MUL;
            S_MUL: state_ff <= S_POW;
            S_TEST: begin
               first_ff <= 1'b1;
               state_ff <= S_CHAINW;
            end
            S_CHAINW: if (!sts.mul_busy) begin
               if ((first_ff && sts.x_one) || sts.x_nm1 || !sts.s_more) begin
                  composite  <= !((first_ff && sts.x_one) || sts.x_nm1);
                  bad_input  <= 1'b0;
                  rsp_tvalid <= 1'b1;
                  state_ff   <= S_DONE;
               end else state_ff <= S_CHAIN;
               first_ff <= 1'b0;
            end
            S_CHAIN: state_ff <= S_CHAINW;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: rtl/mrw_checker.sv
// Port-level checker for the Miller-Rabin witness test.
`timescale 1ns / 1ps
`include "miller_rabin_witness_test_defines.svh"
module mrw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   `MRW_ASSERT_NOW(a_bad_not_comp, clock, reset, rsp_tvalid && rsp_tdata[1], !rsp_tdata[0])
   `MRW_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !rsp_tvalid)
   `MRW_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
endmodule

bind miller_rabin_witness_test mrw_checker u_chk (.*);

// File: tb/testbench.sv
// Testbench for the Miller-Rabin witness test: random and directed candidates, self-checking.
`timescale 1ns / 1ps
module testbench;
   localparam int W = 31;
   localparam int HOLD_CYCLES = 12000;

   typedef struct packed {
      logic [W-1:0] cand;
      logic [W-1:0] wit;
   } mr_item_type;

   typedef struct packed {
      logic composite;
      logic bad_input;
   } mr_verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   mr_item_type    pending_items[$];
   mr_verdict_type verdicts_due[$];
   int             errors = 0;
   int             sent = 0;
   bit             calm = 0;
   bit             hold = 0;
   bit             req_fired = 0;

   miller_rabin_witness_test #(.NUM_WIDTH(W)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [W:0] mod_mul(input logic [W:0] x, input logic [W:0] y,
                                          input logic [W:0] n);
      logic [W+1:0] r;
      r = '0;
      for (int i = W - 1; i >= 0; i--) begin
         r = r + r;
         if (r >= {1'b0, n}) r = r - {1'b0, n};
         if (y[i]) begin
            r = r + {1'b0, x};
            if (r >= {1'b0, n}) r = r - {1'b0, n};
         end
      end
      return r[W:0];
   endfunction

   function automatic mr_verdict_type witness_verdict(input mr_item_type it);
      logic [W:0] n, a, d, x, acc, b;
      int s;
      mr_verdict_type v;
      n = {1'b0, it.cand};
      a = {1'b0, it.wit};
      v = '0;
      if (n < (W+1)'(5) || a < (W+1)'(2) || a > n - (W+1)'(2)) begin
         v.bad_input = 1'b1;
         return v;
      end
      if (!n[0]) begin
         v.composite = 1'b1;
         return v;
      end
      d = n - (W+1)'(1);
      s = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      acc = (W+1)'(1);
      b = a;
      while (d != '0) begin
         if (d[0]) acc = mod_mul(acc, b, n);
         b = mod_mul(b, b, n);
         d = d >> 1;
      end
      x = acc;
      v.composite = 1'b1;
      if (x == (W+1)'(1) || x == n - (W+1)'(1)) v.composite = 1'b0;
      else begin
         for (int i = 1; i < s; i++) begin
            x = mod_mul(x, x, n);
            if (x == n - (W+1)'(1)) begin
               v.composite = 1'b0;
               break;
            end
         end
      end
      return v;
   endfunction

   function automatic int unsigned rnd_odd_small();
      return $urandom_range(5, 200000) | 32'd1;
   endfunction

   task automatic add_item(input int unsigned c, input int unsigned w);
      mr_item_type it;
      it.cand = W'(c);
      it.wit  = W'(w);
      pending_items.push_back(it);
   endtask

   // transfer bookkeeping and prediction
   always @(posedge clock) begin
      mr_item_type it;
      req_fired <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         it = pending_items.pop_front();
         verdicts_due.push_back(witness_verdict(it));
         sent <= sent + 1;
      end
   end

   // driver
   always @(negedge clock) begin
      mr_item_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
            head = pending_items[0];
            req_tvalid <= 1'b1;
            req_tdata  <= {2'b00, head.wit, head.cand};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      mr_verdict_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.composite = rsp_tdata[0];
         got.bad_input = rsp_tdata[1];
         if (verdicts_due.size() == 0) begin
            $error("unexpected result %b", got);
            errors++;
         end else begin
            want = verdicts_due.pop_front();
            if (got.composite !== want.composite) begin
               $error("composite expected %b actual %b", want.composite, got.composite);
               errors++;
            end
            if (got.bad_input !== want.bad_input) begin
               $error("bad_input expected %b actual %b", want.bad_input, got.bad_input);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !hold && (calm || $urandom_range(99) >= 17);
   end

   // long receiver stall
   initial begin
      wait (sent == 40);
      hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold = 1'b0;
   end

   // stretch without idling
   initial begin
      wait (sent == 80);
      calm = 1'b1;
      wait (sent == 105);
      calm = 1'b0;
   end

   initial begin
      int unsigned n;
      // directed: bad inputs, evens, small primes, extremes
      add_item(0, 0);
      add_item(4, 2);
      add_item(5, 1);
      add_item(5, 2);
      add_item(5, 3);
      add_item(5, 4);
      add_item(6, 2);
      add_item(6, 4);
      add_item(9, 2);
      add_item(561, 2);
      add_item(2047, 2);
      add_item(97, 96);
      add_item(97, 95);
      add_item(2147483647, 2);
      add_item(2147483647, 2147483645);
      add_item(2147483647, 2147483646);
      add_item(2147483647, 2147483647);
      add_item(2147483646, 3);
      add_item(2147483645, 2147483643);
      add_item(3, 2147483647);
      add_item(1, 0);
      add_item(2147483647, 0);
      for (int k = 0; k < 108; k++) begin
         case ($urandom_range(9))
            0: add_item($urandom, $urandom);
            1, 2: begin
               n = rnd_odd_small();
               add_item(n, $urandom_range(2, n - 2));
            end
            3: begin
               n = ($urandom & 32'h7FFF_FFFF) | 32'd1;
               if (n < 5) n = 5;
               add_item(n, n - $urandom_range(0, 3));
            end
            default: begin
               n = ($urandom & 32'h7FFF_FFFF) | 32'h4000_0001;
               add_item(n, $urandom_range(2, n - 2));
            end
         endcase
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending_items.size() == 0);
      wait (verdicts_due.size() == 0);
      repeat (5000) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
